// ===== src/clns_pkg.sv =====
// ============================================================================
// clns_pkg
// Shared types, codes and constants of the character LCD nibble sequencer.
// ============================================================================
package clns_pkg;

    typedef enum logic [2:0] {
        MODE_CHAR   = 3'd0,
        MODE_CMD    = 3'd1,
        MODE_INIT   = 3'd2,
        MODE_CURSOR = 3'd3,
        MODE_FLAG   = 3'd4,
        MODE_SCROLL = 3'd5,
        MODE_BLIGHT = 3'd6,
        MODE_BUTTON = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        WR_BL    = 2'd0,
        WR_PLAIN = 2'd1,
        WR_NIB   = 2'd2,
        WR_BTN   = 2'd3
    } t_wr;

    localparam logic [1:0] PORT_NONE = 2'd0;
    localparam logic [1:0] PORT_B    = 2'd1;
    localparam logic [1:0] PORT_AB   = 2'd2;

    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_STROBE = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    localparam logic [3:0] INIT_LAST_IDX = 4'd11;
    localparam logic [3:0] BYTE_LAST_IDX = 4'd1;

    localparam logic [12:0] WAIT_NONE   = 13'd0;
    localparam logic [12:0] WAIT_STROBE = 13'd1;
    localparam logic [12:0] WAIT_SETTLE = 13'd100;
    localparam logic [12:0] WAIT_WAKE   = WAIT_SETTLE + 13'd4500;
    localparam logic [12:0] WAIT_WAKE3  = WAIT_SETTLE + 13'd150;
    localparam logic [12:0] WAIT_CLEAR  = WAIT_SETTLE + 13'd2000;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h04;
    localparam logic [7:0] ENTRY_LEFT    = 8'h02;
    localparam logic [7:0] CMD_DISP_CTRL = 8'h08;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DDRAM     = 8'h80;
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;
    localparam logic [7:0] INIT_PORT_B   = 8'h01;

    localparam logic [2:0] FLAG_DISPLAY = 3'b100;
    localparam logic [7:0] DISP_INIT    = CMD_DISP_CTRL | {5'd0, FLAG_DISPLAY};
    localparam logic [7:0] ENTRY_INIT   = CMD_ENTRY | ENTRY_LEFT;

    localparam logic [3:0] WAKE_NIB   = 4'h3;
    localparam logic [3:0] WAKE_4BIT  = 4'h2;

    typedef struct packed {
        logic       accept;
        logic       emit;
        t_wr        wr;
        logic       init;
        logic [3:0] idx;
        logic [1:0] ph;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    function automatic logic [3:0] init_nib(input logic [3:0] idx);
        logic [3:0] v;
        case (idx)
            4'd0, 4'd1, 4'd2: v = WAKE_NIB;
            4'd3:             v = WAKE_4BIT;
            4'd4:             v = CMD_FUNC_SET[7:4];
            4'd5:             v = CMD_FUNC_SET[3:0];
            4'd6:             v = DISP_INIT[7:4];
            4'd7:             v = DISP_INIT[3:0];
            4'd8:             v = CMD_CLEAR[7:4];
            4'd9:             v = CMD_CLEAR[3:0];
            4'd10:            v = ENTRY_INIT[7:4];
            4'd11:            v = ENTRY_INIT[3:0];
            default:          v = 4'h0;
        endcase
        return v;
    endfunction

    function automatic logic [12:0] init_wait(input logic [3:0] idx);
        logic [12:0] w;
        case (idx)
            4'd0, 4'd1: w = WAIT_WAKE;
            4'd2:       w = WAIT_WAKE3;
            4'd9:       w = WAIT_CLEAR;
            default:    w = WAIT_SETTLE;
        endcase
        return w;
    endfunction

endpackage

// ===== src/clns_ctrl.sv =====
// ============================================================================
// clns_ctrl
// Sequencer that steps through the port writes of each request.
// ============================================================================
module clns_ctrl
    import clns_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  [2:0] i_mode,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BL    = 5'b00010,
        ST_PLAIN = 5'b00100,
        ST_NIB   = 5'b01000,
        ST_BTN   = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic       r_init, n_init;
    logic [3:0] r_idx, n_idx;
    logic [1:0] r_ph, n_ph;
    logic [3:0] w_last_idx;

    assign w_last_idx = r_init ? INIT_LAST_IDX : BYTE_LAST_IDX;
    assign o_ready    = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_idx   = r_idx;
        n_ph    = r_ph;
        o_cmd        = '0;
        o_cmd.wr     = WR_NIB;
        o_cmd.init   = r_init;
        o_cmd.idx    = r_idx;
        o_cmd.ph     = r_ph;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_idx = 4'd0;
                    n_ph  = PH_SETUP;
                    n_init = 1'b0;
                    case (t_mode'(i_mode))
                        MODE_INIT: begin
                            n_state = ST_BL;
                            n_init  = 1'b1;
                        end
                        MODE_BLIGHT: n_state = ST_BL;
                        MODE_BUTTON: n_state = ST_BTN;
                        default:     n_state = ST_NIB;
                    endcase
                end
            end
            ST_BL: begin
                o_cmd.wr = WR_BL;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_init) begin
                        n_state = ST_PLAIN;
                    end else begin
                        o_cmd.last = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PLAIN: begin
                o_cmd.wr = WR_PLAIN;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_NIB;
                end
            end
            ST_NIB: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_ph == PH_HOLD) begin
                        n_ph = PH_SETUP;
                        if (r_idx == w_last_idx) begin
                            o_cmd.last = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx + 4'd1;
                        end
                    end else begin
                        n_ph = r_ph + 2'd1;
                    end
                end
            end
            ST_BTN: begin
                o_cmd.wr = WR_BTN;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_init  <= 1'b0;
            r_idx   <= 4'd0;
            r_ph    <= PH_SETUP;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_idx   <= n_idx;
            r_ph    <= n_ph;
        end
    end

endmodule

// ===== src/clns_dp.sv =====
// ============================================================================
// clns_dp
// Port latches, display flags, request operands and the output word register.
// ============================================================================
module clns_dp
    import clns_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic [1:0]  i_flag_select,
    input  logic        i_flag_on,
    input  logic [2:0]  i_backlight_level,
    input  logic [7:0]  i_button_pins,
    input  logic        i_ready,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [1:0]  o_port,
    output logic [7:0]  o_gpio_a,
    output logic [7:0]  o_gpio_b,
    output logic [12:0] o_wait_us,
    output logic [4:0]  o_buttons,
    output logic        o_last
);

    logic [7:0]  r_pa, r_pb;
    logic [2:0]  r_flags, n_flags;
    logic        r_auto, n_auto;
    logic [7:0]  r_byte, n_byte;
    logic        r_rs;
    logic [2:0]  r_lvl;
    logic [4:0]  r_btn;
    logic        r_valid;
    logic [1:0]  r_port;
    logic [7:0]  r_gpio_a, r_gpio_b;
    logic [12:0] r_wait;
    logic [4:0]  r_buttons;
    logic        r_last;

    logic [1:0]  w_port;
    logic [7:0]  w_a, w_b;
    logic [12:0] w_wait;
    logic [4:0]  w_btn;
    logic [3:0]  w_nib;
    logic [12:0] w_hold_wait;
    logic [7:0]  w_row_off;

    assign o_stat.out_free = !r_valid || i_ready;
    assign w_row_off = i_row[0] ? ROW1_OFFSET : 8'h00;

    always_comb begin
        n_flags = r_flags;
        n_auto  = r_auto;
        n_byte  = i_data_byte;
        case (t_mode'(i_mode))
            MODE_INIT: begin
                n_flags = FLAG_DISPLAY;
                n_auto  = 1'b0;
            end
            MODE_CURSOR: n_byte = CMD_DDRAM | (i_col + w_row_off);
            MODE_FLAG: begin
                case (i_flag_select)
                    2'd0:    n_flags[2] = i_flag_on;
                    2'd1:    n_flags[1] = i_flag_on;
                    2'd2:    n_flags[0] = i_flag_on;
                    default: n_flags = r_flags;
                endcase
                n_byte = CMD_DISP_CTRL | {5'd0, n_flags};
            end
            MODE_SCROLL: begin
                n_auto = i_flag_on;
                n_byte = ENTRY_INIT | {7'd0, i_flag_on};
            end
            default: n_byte = i_data_byte;
        endcase
    end

    assign w_nib = i_cmd.init ? init_nib(i_cmd.idx)
                              : (i_cmd.idx[0] ? r_byte[3:0] : r_byte[7:4]);
    assign w_hold_wait = i_cmd.init ? init_wait(i_cmd.idx) : WAIT_SETTLE;

    always_comb begin
        w_port = PORT_B;
        w_a    = 8'h00;
        w_b    = 8'h00;
        w_wait = WAIT_NONE;
        w_btn  = 5'd0;
        case (i_cmd.wr)
            WR_BL: begin
                w_port = PORT_AB;
                w_a    = {~r_lvl[1], ~r_lvl[0], r_pa[5:0]};
                w_b    = {r_pb[7:1], ~r_lvl[2]};
            end
            WR_PLAIN: w_b = INIT_PORT_B;
            WR_NIB: begin
                w_b = {r_rs, 1'b0, (i_cmd.ph == PH_STROBE),
                       w_nib[0], w_nib[1], w_nib[2], w_nib[3], r_pb[0]};
                w_wait = (i_cmd.ph == PH_HOLD) ? w_hold_wait : WAIT_STROBE;
            end
            WR_BTN: begin
                w_port = PORT_NONE;
                w_btn  = r_btn;
            end
            default: w_port = PORT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa    <= 8'h00;
            r_pb    <= 8'h00;
            r_flags <= 3'd0;
            r_auto  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_flags <= n_flags;
                r_auto  <= n_auto;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
                if (w_port != PORT_NONE) begin
                    r_pb <= w_b;
                end
                if (w_port == PORT_AB) begin
                    r_pa <= w_a;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= n_byte;
            r_rs   <= (t_mode'(i_mode) == MODE_CHAR);
            r_lvl  <= (t_mode'(i_mode) == MODE_INIT) ? 3'b111 : i_backlight_level;
            r_btn  <= ~i_button_pins[4:0];
        end
        if (i_cmd.emit) begin
            r_port    <= w_port;
            r_gpio_a  <= w_a;
            r_gpio_b  <= w_b;
            r_wait    <= w_wait;
            r_buttons <= w_btn;
            r_last    <= i_cmd.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_port    = r_port;
    assign o_gpio_a  = r_gpio_a;
    assign o_gpio_b  = r_gpio_b;
    assign o_wait_us = r_wait;
    assign o_buttons = r_buttons;
    assign o_last    = r_last;

endmodule

// ===== src/char_lcd_nibble_sequencer_top.sv =====
// ============================================================================
// char_lcd_nibble_sequencer_top
// Turns display requests into timed port-expander writes for a 4-bit LCD.
// ============================================================================
// A byte request yields six words, one per cycle when the output is taken.
// Init yields 38 words, backlight and button reads one word each.
// The sequencer leaves idle on acceptance and then emits the words into the output
// register; it returns to idle, ready for the next request, as the last word is
// registered, so it takes no new request while one is still being emitted.
// Synchronous active-low reset clears latches, flags and the sequencer.
module char_lcd_nibble_sequencer_top
    import clns_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic [1:0]  i_flag_select,
    input  logic        i_flag_on,
    input  logic [2:0]  i_backlight_level,
    input  logic [7:0]  i_button_pins,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_port,
    output logic [7:0]  o_gpio_a,
    output logic [7:0]  o_gpio_b,
    output logic [12:0] o_wait_us,
    output logic [4:0]  o_buttons,
    output logic        o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    clns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    clns_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_mode            (i_mode),
        .i_data_byte       (i_data_byte),
        .i_row             (i_row),
        .i_col             (i_col),
        .i_flag_select     (i_flag_select),
        .i_flag_on         (i_flag_on),
        .i_backlight_level (i_backlight_level),
        .i_button_pins     (i_button_pins),
        .i_ready           (i_ready),
        .o_stat            (w_stat),
        .o_valid           (o_valid),
        .o_port            (o_port),
        .o_gpio_a          (o_gpio_a),
        .o_gpio_b          (o_gpio_b),
        .o_wait_us         (o_wait_us),
        .o_buttons         (o_buttons),
        .o_last            (o_last)
    );

    a_btn_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_port != PORT_NONE) |-> (o_buttons == 5'd0))
        else $error("button bits set on a port write");

    a_ab_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_port == PORT_AB) |-> (o_wait_us == WAIT_NONE))
        else $error("backlight write carries a hold time");

    a_strobe_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gpio_b[5] |-> (o_wait_us == WAIT_STROBE) && (o_port == PORT_B))
        else $error("enable-high write with wrong hold time");

    a_strobe_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_gpio_b[5])
        else $error("request ended with enable high");

endmodule
